// ===== hdl/rdwm_pkg.sv =====
// shared types, widths and helpers for the radial disk warp map
`default_nettype none

package rdwm_pkg;

    localparam int CFG_W      = 12;
    localparam int COORD_W    = 11;
    localparam int OUT_W      = 17;
    localparam int GUARD_BITS = 12;

    localparam logic [CFG_W-1:0] COLS_RESET = 12'd640;
    localparam logic [CFG_W-1:0] ROWS_RESET = 12'd480;

    localparam int DX_W    = CFG_W + 1;
    localparam int SQ_W    = 2 * CFG_W + 2;
    localparam int XS_W    = 2 * CFG_W + 1;
    localparam int M_W     = 2 * CFG_W - 1;
    localparam int ROOT_W  = (SQ_W + 2 * GUARD_BITS) / 2;
    localparam int RADQ_W  = 2 * ROOT_W;
    localparam int SREM_W  = ROOT_W + 2;
    localparam int PX_W    = XS_W + ROOT_W + 1;
    localparam int NUM_W   = 64;
    localparam int SHIFT   = GUARD_BITS + 2;
    localparam int NSH_W   = NUM_W - SHIFT;
    localparam int QUO_W   = 24;
    localparam int DIV_W   = M_W + QUO_W;
    localparam int RES_W   = QUO_W + 3;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 17'sh0FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 17'sh10000;

    typedef enum logic [0:0] {
        REG_COLS = 1'b0,
        REG_ROWS = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic                    special;
        logic signed [XS_W-1:0]  xs;
        logic signed [XS_W-1:0]  ys;
        logic [M_W-1:0]          m;
    } sqrt_pay_t;

    typedef struct packed {
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [RADQ_W-1:0] radq;
        sqrt_pay_t         pay;
    } sqrt_cell_t;

    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [DIV_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        logic           special;
        logic [M_W-1:0] m;
        div_lane_t      lx;
        div_lane_t      ly;
    } div_cell_t;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [RES_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > RES_W'(OUT_MAX))
            r = OUT_MAX;
        else if (v < RES_W'(OUT_MIN))
            r = OUT_MIN;
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rdwm_intf.sv =====
// pixel and coordinate stream interfaces
`default_nettype none

interface rdwm_in_if;
    logic                           valid;
    logic                           ready;
    logic [rdwm_pkg::COORD_W-1:0]   pixel_col;
    logic [rdwm_pkg::COORD_W-1:0]   pixel_row;

    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface rdwm_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [rdwm_pkg::OUT_W-1:0]  source_x;
    logic signed [rdwm_pkg::OUT_W-1:0]  source_y;

    modport source (output valid, output source_x, output source_y, input ready);
    modport sink   (input valid, input source_x, input source_y, output ready);
endinterface

`default_nettype wire

// ===== hdl/radial_disk_warp_map.sv =====
// radial disk warp map top level: front end, root and divider cell chains, output skid
//
//  channel     dir  word                      handshake
//  pixel_in    in   pixel_col, pixel_row      valid/ready
//  coord_out   out  source_x, source_y        valid/ready
//  write_*     in   index, data               write_enable, no wait
//
//  one word per cycle sustained while the skid is empty
//  the path from accept to coord_out.valid runs through the 25 root cells and the 24 divider cells
//  all stages advance together; a two-word output skid absorbs a coord_out stall
//  ready drops only while the skid holds a second word
//  reset clears valid bits and loads 640 by 480
`default_nettype none

module radial_disk_warp_map #(
    parameter int MAX_DIMENSION = 2048,
    parameter int FRACTION_BITS = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           write_enable,
    input  rdwm_pkg::reg_index_t           write_index,
    input  logic [rdwm_pkg::CFG_W-1:0]     write_data,
    rdwm_in_if.sink                        pixel_in,
    rdwm_out_if.source                     coord_out
);
    import rdwm_pkg::*;

    localparam int CLAMP_INT = (MAX_DIMENSION > (1 << CFG_W) - 1) ? (1 << CFG_W) - 1
                                                                   : MAX_DIMENSION;
    localparam logic [CFG_W-1:0] CLAMP = CFG_W'(CLAMP_INT);
    localparam int K_W    = CFG_W + FRACTION_BITS;
    localparam int SQRT_N = ROOT_W;
    localparam int DIV_N  = QUO_W;

    logic [CFG_W-1:0] cols_reg, rows_reg;
    logic [CFG_W-1:0] cols_c, rows_c, dmin;
    logic [CFG_W-2:0] rad;
    logic [K_W-1:0]   kx, ky;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
        end
        else if (write_enable)
        begin
            case (write_index)
                REG_COLS: cols_reg <= write_data;
                REG_ROWS: rows_reg <= write_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cols_c = (cols_reg > CLAMP) ? CLAMP : cols_reg;
        rows_c = (rows_reg > CLAMP) ? CLAMP : rows_reg;
        dmin   = (rows_c < cols_c) ? rows_c : cols_c;
        rad    = dmin[CFG_W-1:1];
        kx     = (K_W'(cols_c) << FRACTION_BITS) + K_W'(1);
        ky     = (K_W'(rows_c) << FRACTION_BITS) + K_W'(1);
    end

    logic en;
    logic main_v_reg, skid_v_reg;
    logic accept;

    assign en             = !skid_v_reg;
    assign pixel_in.ready = en;
    assign accept         = pixel_in.valid && en;

    // stage 1: centred half-pixel offsets
    logic signed [DX_W-1:0] x2_next, y2_next;
    logic signed [DX_W-1:0] s1_x2_reg, s1_y2_reg;
    logic [CFG_W-1:0]       s1_ax_reg, s1_ay_reg;
    logic                   s1_v_reg;

    assign x2_next = $signed({1'b0, pixel_in.pixel_col, 1'b0}) - $signed({1'b0, cols_c});
    assign y2_next = $signed({1'b0, pixel_in.pixel_row, 1'b0}) - $signed({1'b0, rows_c});

    // stage 2: squares and sector test products
    logic signed [DX_W-1:0]  s2_x2_reg, s2_y2_reg;
    logic [CFG_W-1:0]        s2_ax_reg, s2_ay_reg;
    logic [2*CFG_W-1:0]      s2_axsq_reg, s2_aysq_reg, s2_cay_reg, s2_rax_reg;
    logic                    s2_v_reg;

    // stage 3: sector select
    logic signed [DX_W-1:0]  s3_x2_reg, s3_y2_reg;
    logic [CFG_W-1:0]        s3_s_reg, s3_d_reg;
    logic [SQ_W-1:0]         s3_sq_reg;
    logic                    s3_special_reg, s3_v_reg;
    logic                    casea;

    assign casea = (s2_ax_reg != '0) && (s2_cay_reg <= s2_rax_reg);

    // stage 4: scale products, feeds root chain
    logic signed [XS_W:0]    xs_full, ys_full;
    logic [M_W-1:0]          m_next;
    sqrt_cell_t              sq_d [0:SQRT_N];
    logic                    sq_v [0:SQRT_N];

    assign xs_full = s3_x2_reg * $signed({1'b0, s3_s_reg});
    assign ys_full = s3_y2_reg * $signed({1'b0, s3_s_reg});
    assign m_next  = s3_d_reg * rad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            sq_v[0]  <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= accept;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            sq_v[0]  <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x2_reg   <= x2_next;
            s1_y2_reg   <= y2_next;
            s1_ax_reg   <= x2_next[DX_W-1] ? CFG_W'(-x2_next) : x2_next[CFG_W-1:0];
            s1_ay_reg   <= y2_next[DX_W-1] ? CFG_W'(-y2_next) : y2_next[CFG_W-1:0];

            s2_x2_reg   <= s1_x2_reg;
            s2_y2_reg   <= s1_y2_reg;
            s2_ax_reg   <= s1_ax_reg;
            s2_ay_reg   <= s1_ay_reg;
            s2_axsq_reg <= s1_ax_reg * s1_ax_reg;
            s2_aysq_reg <= s1_ay_reg * s1_ay_reg;
            s2_cay_reg  <= cols_c * s1_ay_reg;
            s2_rax_reg  <= rows_c * s1_ax_reg;

            s3_x2_reg      <= s2_x2_reg;
            s3_y2_reg      <= s2_y2_reg;
            s3_s_reg       <= casea ? cols_c : rows_c;
            s3_d_reg       <= casea ? s2_ax_reg : s2_ay_reg;
            s3_sq_reg      <= SQ_W'(s2_axsq_reg) + SQ_W'(s2_aysq_reg);
            s3_special_reg <= (rad == '0) || ((s2_ax_reg == '0) && (s2_ay_reg == '0));

            sq_d[0].rem         <= '0;
            sq_d[0].root        <= '0;
            sq_d[0].radq        <= {s3_sq_reg, {(RADQ_W-SQ_W){1'b0}}};
            sq_d[0].pay.special <= s3_special_reg;
            sq_d[0].pay.xs      <= xs_full[XS_W-1:0];
            sq_d[0].pay.ys      <= ys_full[XS_W-1:0];
            sq_d[0].pay.m       <= m_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < SQRT_N; gi++)
        begin : g_sqrt
            rdwm_sqrt_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .valid_in  (sq_v[gi]),
                .data_in   (sq_d[gi]),
                .valid_out (sq_v[gi+1]),
                .data_out  (sq_d[gi+1])
            );
        end
    endgenerate

    // stages 5 to 8: radius product, rounding bias, magnitude, overflow check
    logic signed [PX_W-1:0]  s5_px_reg, s5_py_reg;
    logic [M_W-1:0]          s5_m_reg;
    logic                    s5_special_reg, s5_v_reg;
    logic signed [PX_W-1:0]  px_next, py_next;

    assign px_next = sq_d[SQRT_N].pay.xs * $signed({1'b0, sq_d[SQRT_N].root});
    assign py_next = sq_d[SQRT_N].pay.ys * $signed({1'b0, sq_d[SQRT_N].root});

    logic signed [NUM_W-1:0] px64, py64, mbias, nx, ny, nx_sh, ny_sh;

    assign px64  = s5_px_reg;
    assign py64  = s5_py_reg;
    assign mbias = $signed({{(NUM_W-M_W-GUARD_BITS-1){1'b0}}, s5_m_reg, {(GUARD_BITS+1){1'b0}}});
    assign nx    = (px64 <<< FRACTION_BITS) + (kx[0] ? mbias : '0);
    assign ny    = (py64 <<< FRACTION_BITS) + (ky[0] ? mbias : '0);
    assign nx_sh = nx >>> SHIFT;
    assign ny_sh = ny >>> SHIFT;

    logic signed [NSH_W-1:0] s6_nx_reg, s6_ny_reg;
    logic                    s6_negx_reg, s6_negy_reg;
    logic [M_W-1:0]          s6_m_reg;
    logic                    s6_special_reg, s6_v_reg;

    logic signed [NSH_W-1:0] m_s, ax_next, ay_next;

    assign m_s     = $signed({{(NSH_W-M_W){1'b0}}, s6_m_reg});
    assign ax_next = s6_negx_reg ? (-s6_nx_reg + m_s - NSH_W'(1)) : s6_nx_reg;
    assign ay_next = s6_negy_reg ? (-s6_ny_reg + m_s - NSH_W'(1)) : s6_ny_reg;

    logic [DIV_W-1:0]        s7_ax_reg, s7_ay_reg;
    logic                    s7_negx_reg, s7_negy_reg;
    logic [M_W-1:0]          s7_m_reg;
    logic                    s7_special_reg, s7_v_reg;

    div_cell_t               dv_d [0:DIV_N];
    logic                    dv_v [0:DIV_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
            dv_v[0]  <= 1'b0;
        end
        else if (en)
        begin
            s5_v_reg <= sq_v[SQRT_N];
            s6_v_reg <= s5_v_reg;
            s7_v_reg <= s6_v_reg;
            dv_v[0]  <= s7_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_px_reg      <= px_next;
            s5_py_reg      <= py_next;
            s5_m_reg       <= sq_d[SQRT_N].pay.m;
            s5_special_reg <= sq_d[SQRT_N].pay.special;

            s6_nx_reg      <= nx_sh[NSH_W-1:0];
            s6_ny_reg      <= ny_sh[NSH_W-1:0];
            s6_negx_reg    <= nx[NUM_W-1];
            s6_negy_reg    <= ny[NUM_W-1];
            s6_m_reg       <= s5_m_reg;
            s6_special_reg <= s5_special_reg;

            s7_ax_reg      <= ax_next[DIV_W-1:0];
            s7_ay_reg      <= ay_next[DIV_W-1:0];
            s7_negx_reg    <= s6_negx_reg;
            s7_negy_reg    <= s6_negy_reg;
            s7_m_reg       <= s6_m_reg;
            s7_special_reg <= s6_special_reg;

            dv_d[0].special <= s7_special_reg;
            dv_d[0].m       <= s7_m_reg;
            dv_d[0].lx.neg  <= s7_negx_reg;
            dv_d[0].lx.ovf  <= s7_ax_reg[DIV_W-1:QUO_W] >= s7_m_reg;
            dv_d[0].lx.rem  <= s7_ax_reg;
            dv_d[0].lx.quo  <= '0;
            dv_d[0].ly.neg  <= s7_negy_reg;
            dv_d[0].ly.ovf  <= s7_ay_reg[DIV_W-1:QUO_W] >= s7_m_reg;
            dv_d[0].ly.rem  <= s7_ay_reg;
            dv_d[0].ly.quo  <= '0;
        end
    end

    generate
        for (gi = 0; gi < DIV_N; gi++)
        begin : g_div
            rdwm_div_cell #(
                .STEP (DIV_N - 1 - gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .valid_in  (dv_v[gi]),
                .data_in   (dv_d[gi]),
                .valid_out (dv_v[gi+1]),
                .data_out  (dv_d[gi+1])
            );
        end
    endgenerate

    // stage 9: add centre, saturate
    logic signed [RES_W-1:0] offx_s, offy_s, qx_s, qy_s, resx, resy;
    logic signed [OUT_W-1:0] fx_next, fy_next;
    div_cell_t               dl;

    assign dl     = dv_d[DIV_N];
    assign offx_s = $signed({{(RES_W-K_W+1){1'b0}}, kx[K_W-1:1]});
    assign offy_s = $signed({{(RES_W-K_W+1){1'b0}}, ky[K_W-1:1]});
    assign qx_s   = dl.lx.neg ? -$signed({{(RES_W-QUO_W){1'b0}}, dl.lx.quo})
                              :  $signed({{(RES_W-QUO_W){1'b0}}, dl.lx.quo});
    assign qy_s   = dl.ly.neg ? -$signed({{(RES_W-QUO_W){1'b0}}, dl.ly.quo})
                              :  $signed({{(RES_W-QUO_W){1'b0}}, dl.ly.quo});
    assign resx   = offx_s + qx_s;
    assign resy   = offy_s + qy_s;

    always_comb
    begin
        if (dl.special)
        begin
            fx_next = sat_out(offx_s);
            fy_next = sat_out(offy_s);
        end
        else
        begin
            fx_next = dl.lx.ovf ? (dl.lx.neg ? OUT_MIN : OUT_MAX) : sat_out(resx);
            fy_next = dl.ly.ovf ? (dl.ly.neg ? OUT_MIN : OUT_MAX) : sat_out(resy);
        end
    end

    logic                    fin_v_reg;
    logic signed [OUT_W-1:0] fin_x_reg, fin_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_v_reg <= 1'b0;
        else if (en)
            fin_v_reg <= dv_v[DIV_N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_x_reg <= fx_next;
            fin_y_reg <= fy_next;
        end
    end

    // output skid
    logic                    push, pop;
    logic signed [OUT_W-1:0] main_x_reg, main_y_reg, skid_x_reg, skid_y_reg;

    assign push = fin_v_reg && en;
    assign pop  = main_v_reg && coord_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (pop)
                skid_v_reg <= 1'b0;
        end
        else if (push && !pop && main_v_reg)
            skid_v_reg <= 1'b1;
        else if (push)
            main_v_reg <= 1'b1;
        else if (pop)
            main_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (pop)
            begin
                main_x_reg <= skid_x_reg;
                main_y_reg <= skid_y_reg;
            end
        end
        else if (push && !pop && main_v_reg)
        begin
            skid_x_reg <= fin_x_reg;
            skid_y_reg <= fin_y_reg;
        end
        else if (push)
        begin
            main_x_reg <= fin_x_reg;
            main_y_reg <= fin_y_reg;
        end
    end

    assign coord_out.valid    = main_v_reg;
    assign coord_out.source_x = main_x_reg;
    assign coord_out.source_y = main_y_reg;

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> main_v_reg)
        else $error("skid word held without a main word");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(main_v_reg && !coord_out.ready))
        else $error("skid filled without an output stall");

    a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(fin_v_reg) && $stable(dv_v[0]))
        else $error("cell chain moved while stalled");

endmodule

`default_nettype wire

// ===== hdl/rdwm_sqrt_cell.sv =====
// one digit step of the pipelined square root, payload carried alongside
`default_nettype none

module rdwm_sqrt_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    valid_in,
    input  rdwm_pkg::sqrt_cell_t    data_in,
    output logic                    valid_out,
    output rdwm_pkg::sqrt_cell_t    data_out
);
    import rdwm_pkg::*;

    logic [SREM_W+1:0] rr;
    logic [SREM_W+1:0] trial;
    logic              ge;
    sqrt_cell_t        data_next;
    logic              valid_reg;
    sqrt_cell_t        data_reg;

    always_comb
    begin
        rr    = {data_in.rem, data_in.radq[RADQ_W-1 -: 2]};
        trial = {2'b00, data_in.root, 2'b01};
        ge    = rr >= trial;
        data_next      = data_in;
        data_next.rem  = ge ? SREM_W'(rr - trial) : rr[SREM_W-1:0];
        data_next.root = {data_in.root[ROOT_W-2:0], ge};
        data_next.radq = data_in.radq << 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/rdwm_div_cell.sv =====
// one quotient bit of the two-lane restoring divider
`default_nettype none

module rdwm_div_cell #(
    parameter int STEP = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   valid_in,
    input  rdwm_pkg::div_cell_t    data_in,
    output logic                   valid_out,
    output rdwm_pkg::div_cell_t    data_out
);
    import rdwm_pkg::*;

    logic [DIV_W-1:0] dvsr;
    div_cell_t        data_next;
    logic             valid_reg;
    div_cell_t        data_reg;

    function automatic div_lane_t lane_step(input div_lane_t l, input logic [DIV_W-1:0] d);
        div_lane_t o;
        logic      ge;
        ge    = l.rem >= d;
        o     = l;
        o.rem = ge ? (l.rem - d) : l.rem;
        o.quo = l.quo | (QUO_W'(ge) << STEP);
        return o;
    endfunction

    always_comb
    begin
        dvsr         = DIV_W'(data_in.m) << STEP;
        data_next    = data_in;
        data_next.lx = lane_step(data_in.lx, dvsr);
        data_next.ly = lane_step(data_in.ly, dvsr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire
